>>> hdl/a8w_pkg.sv
// ----------------------------------------------------------------------------
// a8w_pkg
// Shared types, constants and helper functions for the stick quantiser.
// ----------------------------------------------------------------------------
package a8w_pkg;

    localparam int unsigned NumDeadzones = 4;

    typedef logic [2:0]        cfg_index_t;
    typedef logic [6:0]        cfg_data_t;
    typedef logic [6:0]        dz_t;
    typedef logic signed [7:0] axis_t;
    typedef logic [6:0]        mag_t;
    typedef logic [3:0]        sector_t;
    typedef logic [3:0]        dir_t;
    typedef logic [14:0]       sum_t;
    typedef logic [7:0]        root_t;

    // register indexes
    localparam cfg_index_t CFG_DZ_P0S0 = 3'd0;
    localparam cfg_index_t CFG_DZ_P0S1 = 3'd1;
    localparam cfg_index_t CFG_DZ_P1S0 = 3'd2;
    localparam cfg_index_t CFG_DZ_P1S1 = 3'd3;

    localparam dz_t   DzReset   = 7'd1;
    localparam mag_t  MagMax    = 7'd127;
    localparam mag_t  DirMinMag = 7'd64;

    // direction bits
    localparam dir_t DIR_NONE  = 4'd0;
    localparam dir_t DIR_UP    = 4'd1;
    localparam dir_t DIR_DOWN  = 4'd2;
    localparam dir_t DIR_LEFT  = 4'd4;
    localparam dir_t DIR_RIGHT = 4'd8;

    // partial root state between the two halves of the square root
    typedef struct packed {
        logic [14:0] rem;
        logic [15:0] root;
    } sqrt_state_t;

    // centre on 128, clamp at -127
    function automatic axis_t centre_clamp(input logic [7:0] raw);
        axis_t res;
        if (raw == 8'd0)
        begin
            res = -8'sd127;
        end
        else
        begin
            res = axis_t'(raw ^ 8'h80);
        end
        return res;
    endfunction

    function automatic logic [6:0] abs7(input axis_t a);
        logic [7:0] neg;
        neg = 8'(-a);
        return a[7] ? neg[6:0] : a[6:0];
    endfunction

    // quarter of a quadrant from s = (p+q)^2, pp = p^2, qq = q^2
    function automatic logic [1:0] quarter_of(input logic [15:0] s,
                                              input logic [13:0] pp,
                                              input logic [13:0] qq,
                                              input logic p_lt_q);
        logic [16:0] s17;
        logic [16:0] two_pp;
        logic [16:0] two_qq;
        logic [1:0]  res;
        s17    = {1'b0, s};
        two_pp = {2'b00, pp, 1'b0};
        two_qq = {2'b00, qq, 1'b0};
        if (s17 < two_qq)
        begin
            res = 2'd0;
        end
        else if (p_lt_q)
        begin
            res = 2'd1;
        end
        else if (s17 > two_pp)
        begin
            res = 2'd2;
        end
        else
        begin
            res = 2'd3;
        end
        return res;
    endfunction

    // four digit steps of the bitwise square root; hi picks the upper half
    function automatic sqrt_state_t isqrt_steps(input logic [14:0] v_in,
                                                input logic [15:0] r_in,
                                                input logic hi);
        logic [15:0] v;
        logic [15:0] r;
        logic [15:0] t;
        logic [15:0] b;
        sqrt_state_t res;
        v = {1'b0, v_in};
        r = r_in;
        for (int i = 0; i < 4; i++)
        begin
            b = hi ? (16'd1 << (14 - 2 * i)) : (16'd1 << (6 - 2 * i));
            t = r + b;
            if (v >= t)
            begin
                v = v - t;
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
        end
        res.rem  = v[14:0];
        res.root = r;
        return res;
    endfunction

    function automatic dir_t dir_of_sector(input sector_t sec);
        dir_t res;
        case (sec)
            4'd0, 4'd15:  res = DIR_RIGHT;
            4'd1, 4'd2:   res = DIR_UP | DIR_RIGHT;
            4'd3, 4'd4:   res = DIR_UP;
            4'd5, 4'd6:   res = DIR_UP | DIR_LEFT;
            4'd7, 4'd8:   res = DIR_LEFT;
            4'd9, 4'd10:  res = DIR_DOWN | DIR_LEFT;
            4'd11, 4'd12: res = DIR_DOWN;
            4'd13, 4'd14: res = DIR_DOWN | DIR_RIGHT;
            default:      res = DIR_NONE;
        endcase
        return res;
    endfunction

endpackage

>>> hdl/a8w_if.sv
// ----------------------------------------------------------------------------
// a8w_if
// Valid/ready channels for raw stick samples and quantised results.
// ----------------------------------------------------------------------------
interface a8w_sample_if;
    import a8w_pkg::*;

    logic       valid;
    logic       ready;
    logic       pad_index;
    logic       stick_select;
    logic [7:0] raw_x;
    logic [7:0] raw_y;

    modport source (output valid, pad_index, stick_select, raw_x, raw_y, input ready);
    modport sink   (input valid, pad_index, stick_select, raw_x, raw_y, output ready);
endinterface

interface a8w_result_if;
    import a8w_pkg::*;

    logic    valid;
    logic    ready;
    axis_t   axis_x;
    axis_t   axis_y;
    mag_t    magnitude;
    sector_t sector;
    dir_t    direction;

    modport source (output valid, axis_x, axis_y, magnitude, sector, direction,
                    input ready);
    modport sink   (input valid, axis_x, axis_y, magnitude, sector, direction,
                    output ready);
endinterface

>>> hdl/analog_stick_to_eight_way_top.sv
// ----------------------------------------------------------------------------
// analog_stick_to_eight_way_top
// Analog stick sample to magnitude, 22.5 degree sector and eight-way direction.
// ----------------------------------------------------------------------------
// Usage:
//   sample : valid/ready sink, one raw stick sample per transfer (pad, stick,
//            raw x and y bytes, 128 = centre, y grows downwards).
//   result : valid/ready source, one result per sample, in order: centred
//            axes, vector length, sector and direction bits.
//   cfg_*  : write-only deadzone registers, one per pad/stick, index 0..3;
//            writes to higher indexes are dropped. Write only while idle.
//   Five-stage pipeline, every stage registered. One sample per cycle is
//   accepted for as long as results are taken; the rate is one item per
//   cycle, set by the stage registers, the slowest stage being the lower
//   half of the square root. A receiver stall holds the last stage and
//   every occupied stage directly behind it; samples further back still
//   move into empty stages, so up to five samples sit in the pipe and
//   sample.ready drops only once it is full. Nothing is lost or repeated.
//   Reset empties the pipe and sets all deadzones to 1.
// ----------------------------------------------------------------------------
module analog_stick_to_eight_way_top (
    input  logic                  clk,
    input  logic                  rst_n,
    a8w_sample_if.sink            sample,
    a8w_result_if.source          result,
    input  logic                  cfg_we,
    input  a8w_pkg::cfg_index_t   cfg_index,
    input  a8w_pkg::cfg_data_t    cfg_data
);
    import a8w_pkg::*;

    // deadzone registers, indexed by {pad, stick}
    dz_t dz_reg [NumDeadzones];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NumDeadzones; i++)
            begin
                dz_reg[i] <= DzReset;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DZ_P0S0: dz_reg[0] <= cfg_data;
                CFG_DZ_P0S1: dz_reg[1] <= cfg_data;
                CFG_DZ_P1S0: dz_reg[2] <= cfg_data;
                CFG_DZ_P1S1: dz_reg[3] <= cfg_data;
                default:     ;
            endcase
        end
    end

    // stage advance: a stage moves when empty or when the one after moves
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic adv1, adv2, adv3, adv4, adv5;

    assign adv5 = !v5_reg || result.ready;
    assign adv4 = !v4_reg || adv5;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign sample.ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= sample.valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
            if (adv5) v5_reg <= v4_reg;
        end
    end

    // ---- stage 1: centre, clamp, pick quadrant and tangent operands ----
    axis_t      x_next, y_next;
    logic [6:0] ax, ay;
    logic [1:0] quad_next;
    logic       zero_next;
    logic [6:0] p_next, q_next;

    assign x_next = centre_clamp(sample.raw_x);
    assign y_next = centre_clamp(sample.raw_y);
    assign ax     = abs7(x_next);
    assign ay     = abs7(y_next);
    assign zero_next = (x_next == 8'sd0) && (y_next == 8'sd0);

    // angle is measured with up positive, so the y sign flips
    always_comb
    begin
        if (x_next > 8'sd0 && y_next <= 8'sd0)
        begin
            quad_next = 2'd0;
        end
        else if (x_next <= 8'sd0 && y_next < 8'sd0)
        begin
            quad_next = 2'd1;
        end
        else if (x_next < 8'sd0 && y_next >= 8'sd0)
        begin
            quad_next = 2'd2;
        end
        else
        begin
            quad_next = 2'd3;
        end
    end

    // odd quadrants measure from the vertical axis
    assign p_next = quad_next[0] ? ax : ay;
    assign q_next = quad_next[0] ? ay : ax;

    axis_t      x1_reg, y1_reg;
    logic [6:0] p1_reg, q1_reg;
    logic [1:0] quad1_reg;
    logic       zero1_reg;
    dz_t        dz1_reg;

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            x1_reg    <= x_next;
            y1_reg    <= y_next;
            p1_reg    <= p_next;
            q1_reg    <= q_next;
            quad1_reg <= quad_next;
            zero1_reg <= zero_next;
            dz1_reg   <= dz_reg[{sample.pad_index, sample.stick_select}];
        end
    end

    // ---- stage 2: squares ----
    logic [7:0] pq_sum;
    assign pq_sum = {1'b0, p1_reg} + {1'b0, q1_reg};

    axis_t       x2_reg, y2_reg;
    logic [15:0] s2_reg;
    logic [13:0] pp2_reg, qq2_reg;
    logic        plq2_reg;
    logic [1:0]  quad2_reg;
    logic        zero2_reg;
    dz_t         dz2_reg;

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            x2_reg    <= x1_reg;
            y2_reg    <= y1_reg;
            s2_reg    <= {8'd0, pq_sum} * {8'd0, pq_sum};
            pp2_reg   <= {7'd0, p1_reg} * {7'd0, p1_reg};
            qq2_reg   <= {7'd0, q1_reg} * {7'd0, q1_reg};
            plq2_reg  <= p1_reg < q1_reg;
            quad2_reg <= quad1_reg;
            zero2_reg <= zero1_reg;
            dz2_reg   <= dz1_reg;
        end
    end

    // ---- stage 3: sum of squares, sector from tangent compares ----
    sector_t sec_next;
    assign sec_next = zero2_reg ? 4'd0
                    : {quad2_reg, quarter_of(s2_reg, pp2_reg, qq2_reg, plq2_reg)};

    axis_t   x3_reg, y3_reg;
    sum_t    sum3_reg;
    sector_t sec3_reg;
    dz_t     dz3_reg;

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            x3_reg   <= x2_reg;
            y3_reg   <= y2_reg;
            sum3_reg <= 15'({1'b0, pp2_reg} + {1'b0, qq2_reg});
            sec3_reg <= sec_next;
            dz3_reg  <= dz2_reg;
        end
    end

    // ---- stage 4: upper root digits (inside a8w_isqrt) ----
    root_t root;

    a8w_isqrt u_isqrt (
        .clk      (clk),
        .load     (adv4),
        .radicand (sum3_reg),
        .root     (root)
    );

    axis_t   x4_reg, y4_reg;
    sector_t sec4_reg;
    dz_t     dz4_reg;

    always_ff @(posedge clk)
    begin
        if (adv4)
        begin
            x4_reg   <= x3_reg;
            y4_reg   <= y3_reg;
            sec4_reg <= sec3_reg;
            dz4_reg  <= dz3_reg;
        end
    end

    // ---- stage 5: lower root digits, saturate, deadzone, direction ----
    mag_t mag_sat;
    logic dead;
    dir_t dir_next;

    assign mag_sat  = (root > root_t'(MagMax)) ? MagMax : root[6:0];
    assign dead     = mag_sat < dz4_reg;
    assign dir_next = (dead || mag_sat < DirMinMag) ? DIR_NONE : dir_of_sector(sec4_reg);

    axis_t   ox_reg, oy_reg;
    mag_t    omag_reg;
    sector_t osec_reg;
    dir_t    odir_reg;

    always_ff @(posedge clk)
    begin
        if (adv5)
        begin
            ox_reg   <= dead ? 8'sd0 : x4_reg;
            oy_reg   <= dead ? 8'sd0 : y4_reg;
            omag_reg <= dead ? 7'd0 : mag_sat;
            osec_reg <= dead ? 4'd0 : sec4_reg;
            odir_reg <= dir_next;
        end
    end

    assign result.valid     = v5_reg;
    assign result.axis_x    = ox_reg;
    assign result.axis_y    = oy_reg;
    assign result.magnitude = omag_reg;
    assign result.sector    = osec_reg;
    assign result.direction = odir_reg;

endmodule

>>> hdl/a8w_isqrt.sv
// ----------------------------------------------------------------------------
// a8w_isqrt
// Two-half square root: upper four digits registered, lower four combinational.
// ----------------------------------------------------------------------------
module a8w_isqrt (
    input  logic           clk,
    input  logic           load,
    input  a8w_pkg::sum_t  radicand,
    output a8w_pkg::root_t root
);
    import a8w_pkg::*;

    sqrt_state_t mid_reg;
    sqrt_state_t mid_next;
    sqrt_state_t fin;

    assign mid_next = isqrt_steps(radicand, 16'd0, 1'b1);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mid_reg <= mid_next;
        end
    end

    assign fin  = isqrt_steps(mid_reg.rem, mid_reg.root, 1'b0);
    assign root = fin.root[7:0];

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stick quantiser. A short table of hand-picked
// samples (corners, axis ends, diagonals, sector edges, the direction
// threshold) comes first. Then eight phases of random samples, each with a
// deadzone setting and one of four idling patterns. Every result is
// compared field by field with an in-bench model of the centring, length,
// sector and deadzone rules.
// ----------------------------------------------------------------------------
module tb;
    import a8w_pkg::*;

    // one raw stick sample as it goes over the sample channel
    typedef struct packed {
        logic       pad;
        logic       stick;
        logic [7:0] raw_x;
        logic [7:0] raw_y;
    } stick_sample_t;

    // one quantised result as it comes back
    typedef struct packed {
        axis_t   axis_x;
        axis_t   axis_y;
        mag_t    magnitude;
        sector_t sector;
        dir_t    direction;
    } stick_result_t;

    // a row of the directed table: sample, and a typed answer where the
    // answer is obvious (otherwise the model decides)
    typedef struct packed {
        stick_sample_t smp;
        logic          typed;
        stick_result_t want;
    } steer_row_t;

    // travels with each offered sample until its transfer is seen
    typedef struct packed {
        logic          typed;
        stick_result_t want;
    } steer_tag_t;

    localparam int            NumPhases     = 8;
    localparam int            PhaseSamples  = 240;
    localparam int            NumSteerRows  = 23;
    localparam int            LongHoldOff   = 60;
    localparam int            MaxPrinted    = 200;
    localparam stick_result_t NoWant        = '0;

    localparam cfg_index_t DzIndex [NumDeadzones] =
        '{CFG_DZ_P0S0, CFG_DZ_P0S1, CFG_DZ_P1S0, CFG_DZ_P1S1};

    // sector number to direction bits, counterclockwise from right
    localparam dir_t HeadingOfSector [16] = '{
        DIR_RIGHT,           DIR_UP | DIR_RIGHT,  DIR_UP | DIR_RIGHT,  DIR_UP,
        DIR_UP,              DIR_UP | DIR_LEFT,   DIR_UP | DIR_LEFT,   DIR_LEFT,
        DIR_LEFT,            DIR_DOWN | DIR_LEFT, DIR_DOWN | DIR_LEFT, DIR_DOWN,
        DIR_DOWN,            DIR_DOWN | DIR_RIGHT, DIR_DOWN | DIR_RIGHT, DIR_RIGHT
    };

    // raw bytes worth hitting often: clamp point, centre and both ends
    localparam logic [7:0] AxisCorner [8] = '{
        8'd0, 8'd1, 8'd2, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255
    };

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    cfg_index_t cfg_index;
    cfg_data_t  cfg_data;

    a8w_sample_if sample_ch ();
    a8w_result_if result_ch ();

    analog_stick_to_eight_way_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // bench copy of the deadzone registers, indexed {pad, stick}
    dz_t dz_mirror [NumDeadzones];

    stick_result_t expected_q [$];
    steer_tag_t    tag_q [$];

    int sent_count    = 0;
    int checked_count = 0;
    int mismatches    = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_off_left = 0;

    // Directed table. Typed rows: centred stick inside the reset deadzone,
    // the four axis ends and four corners (all at full length, so every
    // direction code shows), and raw 1 (-127). Model-checked rows: the
    // smallest push, the direction threshold either side, exact diagonals
    // (an edge belongs to the higher sector), either side of the 22.5 degree
    // edge, past the 67.5 degree edge, and one-step pushes left and down.
    steer_row_t steer_table [NumSteerRows] = '{
        '{'{1'b0, 1'b0, 8'd128, 8'd128}, 1'b1,
          '{8'sd0, 8'sd0, 7'd0, 4'd0, DIR_NONE}},
        '{'{1'b0, 1'b1, 8'd255, 8'd128}, 1'b1,
          '{8'sd127, 8'sd0, 7'd127, 4'd0, DIR_RIGHT}},
        '{'{1'b1, 1'b0, 8'd255, 8'd0}, 1'b1,
          '{8'sd127, -8'sd127, 7'd127, 4'd2, DIR_UP | DIR_RIGHT}},
        '{'{1'b1, 1'b1, 8'd128, 8'd0}, 1'b1,
          '{8'sd0, -8'sd127, 7'd127, 4'd4, DIR_UP}},
        '{'{1'b0, 1'b0, 8'd0, 8'd0}, 1'b1,
          '{-8'sd127, -8'sd127, 7'd127, 4'd6, DIR_UP | DIR_LEFT}},
        '{'{1'b0, 1'b1, 8'd0, 8'd128}, 1'b1,
          '{-8'sd127, 8'sd0, 7'd127, 4'd8, DIR_LEFT}},
        '{'{1'b1, 1'b0, 8'd0, 8'd255}, 1'b1,
          '{-8'sd127, 8'sd127, 7'd127, 4'd10, DIR_DOWN | DIR_LEFT}},
        '{'{1'b1, 1'b1, 8'd128, 8'd255}, 1'b1,
          '{8'sd0, 8'sd127, 7'd127, 4'd12, DIR_DOWN}},
        '{'{1'b0, 1'b0, 8'd255, 8'd255}, 1'b1,
          '{8'sd127, 8'sd127, 7'd127, 4'd14, DIR_DOWN | DIR_RIGHT}},
        '{'{1'b1, 1'b0, 8'd1, 8'd128}, 1'b1,
          '{-8'sd127, 8'sd0, 7'd127, 4'd8, DIR_LEFT}},
        '{'{1'b0, 1'b1, 8'd129, 8'd128}, 1'b0, NoWant},
        '{'{1'b1, 1'b1, 8'd128, 8'd127}, 1'b0, NoWant},
        '{'{1'b0, 1'b0, 8'd191, 8'd128}, 1'b0, NoWant},
        '{'{1'b0, 1'b1, 8'd192, 8'd128}, 1'b0, NoWant},
        '{'{1'b1, 1'b0, 8'd178, 8'd78}, 1'b0, NoWant},
        '{'{1'b1, 1'b1, 8'd78, 8'd78}, 1'b0, NoWant},
        '{'{1'b0, 1'b0, 8'd78, 8'd178}, 1'b0, NoWant},
        '{'{1'b0, 1'b1, 8'd178, 8'd178}, 1'b0, NoWant},
        '{'{1'b1, 1'b0, 8'd228, 8'd87}, 1'b0, NoWant},
        '{'{1'b1, 1'b1, 8'd228, 8'd86}, 1'b0, NoWant},
        '{'{1'b0, 1'b0, 8'd169, 8'd28}, 1'b0, NoWant},
        '{'{1'b0, 1'b1, 8'd127, 8'd128}, 1'b0, NoWant},
        '{'{1'b1, 1'b0, 8'd128, 8'd129}, 1'b0, NoWant}
    };

    // ------------------------------------------------------------------------
    // Model of one sample. The sector is found by turning the vector a
    // quarter at a time until it lies in the first quadrant, then placing it
    // against the 22.5 / 45 / 67.5 degree edges with exact integer tests:
    // v/u < sqrt2-1 <=> (u+v)^2 < 2u^2, v/u < sqrt2+1 <=> (u+v)^2 > 2v^2.
    // ------------------------------------------------------------------------
    function automatic stick_result_t quantise(input stick_sample_t s, input dz_t dz);
        int            cx;
        int            cy;
        int            u;
        int            v;
        int            t;
        int            turns;
        int            len_sq;
        int            root;
        int            sum_sq;
        int            part;
        int            sec;
        stick_result_t res;
        cx = int'(s.raw_x) - 128;
        cy = int'(s.raw_y) - 128;
        if (cx < -127)
        begin
            cx = -127;
        end
        if (cy < -127)
        begin
            cy = -127;
        end

        len_sq = cx * cx + cy * cy;
        root = 0;
        while ((root + 1) * (root + 1) <= len_sq)
        begin
            root++;
        end
        if (root > int'(MagMax))
        begin
            root = int'(MagMax);
        end

        // angle with up positive, so the raw y is flipped
        sec = 0;
        if (cx != 0 || cy != 0)
        begin
            u = cx;
            v = -cy;
            turns = 0;
            while (!(u > 0 && v >= 0))
            begin
                t = u;
                u = v;
                v = -t;
                turns++;
            end
            sum_sq = (u + v) * (u + v);
            if (sum_sq < 2 * u * u)
            begin
                part = 0;
            end
            else if (v < u)
            begin
                part = 1;
            end
            else if (sum_sq > 2 * v * v)
            begin
                part = 2;
            end
            else
            begin
                part = 3;
            end
            sec = 4 * turns + part;
        end

        if (root < int'(dz))
        begin
            cx = 0;
            cy = 0;
            root = 0;
            sec = 0;
        end

        res.axis_x    = axis_t'(cx);
        res.axis_y    = axis_t'(cy);
        res.magnitude = mag_t'(root);
        res.sector    = sector_t'(sec);
        res.direction = (root < int'(DirMinMag)) ? DIR_NONE : HeadingOfSector[sec];
        return res;
    endfunction

    // one raw axis byte, weighted towards the interesting spots
    function automatic logic [7:0] random_axis();
        logic [7:0] b;
        case ($urandom_range(7, 0))
            0:       b = AxisCorner[$urandom_range(7, 0)];
            1:       b = 8'(120 + $urandom_range(16, 0));
            2:       b = ($urandom_range(1, 0) != 0) ? 8'(128 + $urandom_range(72, 56))
                                                     : 8'(128 - $urandom_range(72, 56));
            default: b = 8'($urandom_range(255, 0));
        endcase
        return b;
    endfunction

    // random sample; some land on diagonals or on the horizontal axis so that
    // exact sector edges come up often
    function automatic stick_sample_t random_sample();
        stick_sample_t s;
        s.pad   = 1'($urandom_range(1, 0));
        s.stick = 1'($urandom_range(1, 0));
        s.raw_x = random_axis();
        case ($urandom_range(7, 0))
            0:       s.raw_y = s.raw_x;
            1:       s.raw_y = 8'(9'd256 - {1'b0, s.raw_x});
            2:       s.raw_y = 8'd128;
            default: s.raw_y = random_axis();
        endcase
        return s;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MaxPrinted)
        begin
            $display("[%0t] mismatch at result %0d: %s", $time, checked_count, what);
        end
    endtask

    // Offer one sample, with random idle cycles first. Returns at the edge of
    // its transfer. The tag is queued before valid rises, so the monitor
    // always finds it at the transfer edge.
    task automatic offer_sample(input stick_sample_t s, input logic typed,
                                input stick_result_t want);
        steer_tag_t tag;
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        tag.typed = typed;
        tag.want  = want;
        tag_q.push_back(tag);
        sample_ch.valid        <= 1'b1;
        sample_ch.pad_index    <= s.pad;
        sample_ch.stick_select <= s.stick;
        sample_ch.raw_x        <= s.raw_x;
        sample_ch.raw_y        <= s.raw_y;
        @(posedge clk);
        while (sample_ch.ready !== 1'b1)
        begin
            @(posedge clk);
        end
        sent_count++;
    endtask

    // stop offering and wait until every transferred sample has its result
    task automatic drain();
        sample_ch.valid <= 1'b0;
        while (checked_count != sent_count)
        begin
            @(posedge clk);
        end
    endtask

    // Write all four deadzones, then one stray write above the last index
    // which the block must drop. Only called with the pipe empty.
    task automatic write_deadzones(input dz_t dz_set [NumDeadzones]);
        cfg_index_t stray_index;
        cfg_data_t  stray_data;
        for (int i = 0; i < NumDeadzones; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= DzIndex[i];
            cfg_data  <= dz_set[i];
            @(posedge clk);
            dz_mirror[i] = dz_set[i];
        end
        stray_index = cfg_index_t'(NumDeadzones + $urandom_range(3, 0));
        stray_data  = cfg_data_t'($urandom_range(127, 0));
        cfg_index <= stray_index;
        cfg_data  <= stray_data;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // generous ceiling; a correct run ends far sooner
    initial
    begin : watchdog
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // Receiver: random back-pressure, or a long hold-off when asked for, the
    // count of which runs down here, one cycle per edge.
    initial
    begin : receiver
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off_left > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_off_left--;
            end
            else
            begin
                result_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Both channels are looked at in one process at each edge, so a
    // sample transfer and a result transfer at the same edge need no
    // ordering between processes. Values read here are the ones from before
    // the edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        stick_sample_t got_in;
        stick_result_t got;
        stick_result_t want;
        steer_tag_t    tag;
        if (rst_n === 1'b1 && sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1)
        begin
            got_in.pad   = sample_ch.pad_index;
            got_in.stick = sample_ch.stick_select;
            got_in.raw_x = sample_ch.raw_x;
            got_in.raw_y = sample_ch.raw_y;
            tag = (tag_q.size() != 0) ? tag_q.pop_front() : '0;
            want = tag.typed ? tag.want : quantise(got_in, dz_mirror[{got_in.pad, got_in.stick}]);
            expected_q.push_back(want);
        end
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            got.axis_x    = result_ch.axis_x;
            got.axis_y    = result_ch.axis_y;
            got.magnitude = result_ch.magnitude;
            got.sector    = result_ch.sector;
            got.direction = result_ch.direction;
            if (expected_q.size() == 0)
            begin
                report_mismatch("result transfer with nothing outstanding");
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.axis_x !== want.axis_x)
                begin
                    report_mismatch($sformatf("axis_x got %0d expected %0d",
                                              got.axis_x, want.axis_x));
                end
                if (got.axis_y !== want.axis_y)
                begin
                    report_mismatch($sformatf("axis_y got %0d expected %0d",
                                              got.axis_y, want.axis_y));
                end
                if (got.magnitude !== want.magnitude)
                begin
                    report_mismatch($sformatf("magnitude got %0d expected %0d",
                                              got.magnitude, want.magnitude));
                end
                if (got.sector !== want.sector)
                begin
                    report_mismatch($sformatf("sector got %0d expected %0d",
                                              got.sector, want.sector));
                end
                if (got.direction !== want.direction)
                begin
                    report_mismatch($sformatf("direction got %0d expected %0d",
                                              got.direction, want.direction));
                end
            end
            checked_count++;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus: reset, directed table under reset deadzones, then the random
    // phases. Phase n uses idling pattern n mod 4: none, sender idle, receiver
    // stall, both.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        dz_t dz_set [NumDeadzones];

        rst_n                  <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_index              <= CFG_DZ_P0S0;
        cfg_data               <= '0;
        sample_ch.valid        <= 1'b0;
        sample_ch.pad_index    <= 1'b0;
        sample_ch.stick_select <= 1'b0;
        sample_ch.raw_x        <= 8'd128;
        sample_ch.raw_y        <= 8'd128;
        for (int i = 0; i < NumDeadzones; i++)
        begin
            dz_mirror[i] = DzReset;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, no idling, reset deadzones
        for (int i = 0; i < NumSteerRows; i++)
        begin
            offer_sample(steer_table[i].smp, steer_table[i].typed, steer_table[i].want);
        end
        drain();

        for (int phase = 0; phase < NumPhases; phase++)
        begin
            // deadzones: all off, all at full length, a mix, then random
            for (int i = 0; i < NumDeadzones; i++)
            begin
                case (phase)
                    0:       dz_set[i] = '0;
                    1:       dz_set[i] = MagMax;
                    2:       dz_set[i] = (i == 0) ? dz_t'(0) : (i == 1) ? MagMax
                                       : (i == 2) ? DirMinMag : DzReset;
                    default: dz_set[i] = dz_t'($urandom_range(127, 0));
                endcase
            end
            write_deadzones(dz_set);

            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 52;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 52;
                end
                default:
                begin
                    send_idle_pct = 38;
                    stall_pct     = 38;
                end
            endcase

            // long receiver hold-off while samples keep coming: the pipe
            // fills and sample.ready must drop without losing anything
            if (phase == 2)
            begin
                hold_off_left = LongHoldOff;
            end

            for (int n = 0; n < PhaseSamples; n++)
            begin
                // sender pauses mid-phase until the pipe has fully emptied
                if (phase == 5 && n == PhaseSamples / 2)
                begin
                    drain();
                end
                offer_sample(random_sample(), 1'b0, NoWant);
            end
            drain();
        end

        // wait beyond the pipe depth to catch any stray result
        repeat (12) @(posedge clk);
        if (expected_q.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
        end

        if (mismatches == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
